// ===== design/hkv_pkg.sv =====
package hkv_pkg;

   // Operation codes carried by a request.
   typedef enum logic [1:0] {
      OP_INSERT     = 2'd0,
      OP_INSERT_NEW = 2'd1,
      OP_VERIFY     = 2'd2,
      OP_REMOVE     = 2'd3
   } op_type;

   // Completion codes carried by a response.
   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_PRESENT = 2'd2,
      STATUS_MISSING = 2'd3
   } status_type;

   typedef struct packed {
      op_type      op;
      logic [63:0] key;
      logic [63:0] value;
   } req_payload_type;

   typedef struct packed {
      status_type  status;
      logic        found;
      logic        match;
      logic [63:0] stored_value;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic load;
      logic read;
      logic eval;
      logic write;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
   } dp_status_type;

   // Golden-ratio multiplier of the bucket hash.
   localparam logic [63:0] GOLDEN64 = 64'h61C8864680B583EB;

endpackage

// ===== design/hkv_stream_if.sv =====
interface hkv_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== design/hashed_key_value_verify_table.sv =====
// Channel   Dir  Payload                                   Handshake
// req_if    in   op[1:0], key[63:0], value[63:0]           valid/ready
// rsp_if    out  status[1:0], found, match, stored[63:0]   valid/ready
//
// Each request passes through products, bucket read, way compare and write back
// before the next request is accepted.
// The response register is loaded on the write-back edge.
// After reset a clearing pass writes one bucket row a cycle, all 2**BUCKET_BITS
// rows in turn, during which req_if.ready stays low.
// A stalled response holds the write-back step until the pending response is taken.
module hashed_key_value_verify_table
   import hkv_pkg::*;
#(
   parameter int BUCKET_BITS = 8,
   parameter int WAYS        = 4
) (
   input logic         clock,
   input logic         reset,
   hkv_stream_if.sink   req_if,
   hkv_stream_if.source rsp_if
);

   cmd_type       cmd;
   dp_status_type dp_status;

   hkv_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   hkv_datapath #(
      .BUCKET_BITS (BUCKET_BITS),
      .WAYS        (WAYS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .dp_status   (dp_status),
      .req_payload (req_if.payload),
      .rsp_payload (rsp_if.payload)
   );

endmodule

// ===== design/hkv_datapath.sv =====
module hkv_datapath
   import hkv_pkg::*;
#(
   parameter int BUCKET_BITS = 8,
   parameter int WAYS        = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   output dp_status_type   dp_status,
   input  req_payload_type req_payload,
   output rsp_payload_type rsp_payload
);

   localparam int NB = 1 << BUCKET_BITS;
   localparam int RW = (WAYS > 1) ? $clog2(WAYS) : 1;

   typedef logic [WAYS-1:0][63:0]   word_row_type;
   typedef logic [WAYS-1:0][RW-1:0] rank_row_type;

   // Bucket storage, one row per bucket.
   word_row_type    key_mem   [NB];
   word_row_type    value_mem [NB];
   logic [WAYS-1:0] valid_mem [NB];
   rank_row_type    rank_mem  [NB];

   op_type              op_ff;
   logic [63:0]         key_ff;
   logic [63:0]         value_ff;
   logic [31:0]         prod_hi_ff;
   logic [31:0]         cross_a_ff;
   logic [31:0]         cross_b_ff;
   logic [BUCKET_BITS-1:0] bucket_ff;
   logic [BUCKET_BITS-1:0] clr_cnt_ff;
   word_row_type        key_row_ff;
   word_row_type        value_row_ff;
   logic [WAYS-1:0]     valid_row_ff;
   rank_row_type        rank_row_ff;
   logic [WAYS-1:0]     hit_oh_ff;
   logic [WAYS-1:0]     free_oh_ff;
   logic [RW-1:0]       hit_rank_ff;
   logic [63:0]         stored_ff;
   logic                found_ff;
   rsp_payload_type     rsp_ff;

   logic [63:0]         prod_lo_lo;
   logic [31:0]         prod_lo_hi;
   logic [31:0]         prod_hi_lo;
   logic [31:0]         hash_sum;
   logic [BUCKET_BITS-1:0] bucket;
   logic [WAYS-1:0]     key_eq;
   logic [WAYS-1:0]     newest;
   logic [WAYS-1:0]     free_oh;
   logic [63:0]         hit_value;
   logic [RW-1:0]       hit_rank;
   word_row_type        key_row_in;
   word_row_type        value_row_in;
   logic [WAYS-1:0]     valid_row_in;
   rank_row_type        rank_row_in;
   logic                word_we;
   logic                meta_we;
   logic [BUCKET_BITS-1:0] meta_addr;
   logic [WAYS-1:0]     meta_valid_wr;
   rank_row_type        meta_rank_wr;
   status_type          status;
   logic                match;

   // Partial products of key times the golden ratio, for the low 64 bits of the product.
   assign prod_lo_lo = {32'd0, req_payload.key[31:0]} * {32'd0, GOLDEN64[31:0]};
   assign prod_lo_hi = req_payload.key[31:0] * GOLDEN64[63:32];
   assign prod_hi_lo = req_payload.key[63:32] * GOLDEN64[31:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_payload.op;
         key_ff     <= req_payload.key;
         value_ff   <= req_payload.value;
         prod_hi_ff <= prod_lo_lo[63:32];
         cross_a_ff <= prod_lo_hi;
         cross_b_ff <= prod_hi_lo;
      end
   end

   // Upper half of the low 64 bits of the product; the bucket is its top bits.
   assign hash_sum = prod_hi_ff + cross_a_ff + cross_b_ff;
   assign bucket   = hash_sum[31 -: BUCKET_BITS];

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         bucket_ff <= bucket;
      end
   end

   // Compare all ways; the newest match has the smallest rank among matches.
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         key_eq[w] = valid_row_ff[w] && (key_row_ff[w] == key_ff);
      end
      for (int w = 0; w < WAYS; w++) begin
         newest[w] = key_eq[w];
         for (int v = 0; v < WAYS; v++) begin
            if (v != w && key_eq[v] && (rank_row_ff[v] < rank_row_ff[w])) begin
               newest[w] = 1'b0;
            end
         end
      end
      hit_value = '0;
      hit_rank  = '0;
      for (int w = 0; w < WAYS; w++) begin
         hit_value = hit_value | (value_row_ff[w] & {64{newest[w]}});
         hit_rank  = hit_rank | (rank_row_ff[w] & {RW{newest[w]}});
      end
   end

   // Lowest free way, as a one-hot mask.
   assign free_oh = ~valid_row_ff & (valid_row_ff + WAYS'(1));

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         hit_oh_ff   <= newest;
         free_oh_ff  <= free_oh;
         hit_rank_ff <= hit_rank;
         stored_ff   <= hit_value;
         found_ff    <= |key_eq;
      end
   end

   // Row update and response for the operation.
   always_comb begin
      key_row_in   = key_row_ff;
      value_row_in = value_row_ff;
      valid_row_in = valid_row_ff;
      rank_row_in  = rank_row_ff;
      word_we      = 1'b0;
      meta_we      = 1'b0;
      status       = STATUS_DONE;
      match        = 1'b0;
      case (op_ff)
         OP_INSERT, OP_INSERT_NEW: begin
            if (op_ff == OP_INSERT_NEW && found_ff) begin
               status = STATUS_PRESENT;
            end else if (free_oh_ff == '0) begin
               status = STATUS_FULL;
            end else begin
               word_we      = 1'b1;
               meta_we      = 1'b1;
               valid_row_in = valid_row_ff | free_oh_ff;
               for (int w = 0; w < WAYS; w++) begin
                  if (free_oh_ff[w]) begin
                     key_row_in[w]   = key_ff;
                     value_row_in[w] = value_ff;
                     rank_row_in[w]  = '0;
                  end else if (valid_row_ff[w]) begin
                     rank_row_in[w] = rank_row_ff[w] + RW'(1);
                  end
               end
            end
         end
         OP_VERIFY: begin
            match = found_ff && (stored_ff == value_ff);
         end
         OP_REMOVE: begin
            if (!found_ff) begin
               status = STATUS_MISSING;
            end else begin
               meta_we      = 1'b1;
               valid_row_in = valid_row_ff & ~hit_oh_ff;
               for (int w = 0; w < WAYS; w++) begin
                  if (hit_oh_ff[w]) begin
                     rank_row_in[w] = '0;
                  end else if (valid_row_ff[w] && (rank_row_ff[w] > hit_rank_ff)) begin
                     rank_row_in[w] = rank_row_ff[w] - RW'(1);
                  end
               end
            end
         end
         default: begin
            status = STATUS_DONE;
         end
      endcase
   end

   // The clearing pass owns the metadata write port after reset.
   assign meta_addr     = cmd.clear ? clr_cnt_ff : bucket_ff;
   assign meta_valid_wr = cmd.clear ? '0 : valid_row_in;
   assign meta_rank_wr  = cmd.clear ? '0 : rank_row_in;

   always_ff @(posedge clock) begin
      if (cmd.write && word_we) begin
         key_mem[bucket_ff]   <= key_row_in;
         value_mem[bucket_ff] <= value_row_in;
      end
      if (cmd.read) begin
         key_row_ff   <= key_mem[bucket];
         value_row_ff <= value_mem[bucket];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear || (cmd.write && meta_we)) begin
         valid_mem[meta_addr] <= meta_valid_wr;
         rank_mem[meta_addr]  <= meta_rank_wr;
      end
      if (cmd.read) begin
         valid_row_ff <= valid_mem[bucket];
         rank_row_ff  <= rank_mem[bucket];
      end
   end

   // Clearing pass counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear) begin
         clr_cnt_ff <= clr_cnt_ff + BUCKET_BITS'(1);
      end
   end

   assign dp_status.clear_last = &clr_cnt_ff;

   // Response register.
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         rsp_ff.status       <= status;
         rsp_ff.found        <= found_ff;
         rsp_ff.match        <= match;
         rsp_ff.stored_value <= stored_ff;
      end
   end

   assign rsp_payload = rsp_ff;

   a_hit_single: assert property (@(posedge clock) disable iff (reset)
      cmd.eval |=> $onehot0(hit_oh_ff))
      else $error("more than one newest match in a bucket");

   a_found_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.eval |=> (found_ff == (hit_oh_ff != '0)))
      else $error("found flag disagrees with the selected way");

   a_free_single: assert property (@(posedge clock) disable iff (reset)
      cmd.eval |=> $onehot0(free_oh_ff))
      else $error("more than one free way selected");

endmodule

// ===== design/hkv_controller.sv =====
module hkv_controller
   import hkv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type dp_status,
   output cmd_type       cmd
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_HASH  = 5'b00100,
      ST_LOOK  = 5'b01000,
      ST_WRITE = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Sequencing of the clearing pass after reset and of one request: hash, bucket read, compare, write back.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (dp_status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            cmd.read = 1'b1;
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            cmd.eval = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.write = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Response valid flag.
   always_comb begin
      if (cmd.write) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before it was taken");

   a_load_read: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.read)
      else $error("accepted request not followed by a bucket read");

endmodule
